>>> rtl/sign_magnitude_rational_alu_top_assert.svh
`ifndef SIGN_MAGNITUDE_RATIONAL_ALU_TOP_ASSERT_SVH
`define SIGN_MAGNITUDE_RATIONAL_ALU_TOP_ASSERT_SVH

// same-cycle implication
`define SMRA_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("smra check failed");

// next-cycle implication
`define SMRA_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("smra check failed");

`endif

>>> rtl/smra_pkg.sv
package smra_pkg;

  localparam int MAG_WIDTH_DEF = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_REDUCED     = 3'd1;
  localparam logic [2:0] ST_IRREDUCIBLE = 3'd2;
  localparam logic [2:0] ST_OVERFLOW    = 3'd3;
  localparam logic [2:0] ST_DIVZERO     = 3'd4;

  typedef enum logic [1:0] {
    DS_AB,
    DS_AG,
    DS_BG
  } divsrc_t;

  typedef struct packed {
    logic    load;
    logic    mul_start;
    logic    mul_step;
    logic    div_start;
    divsrc_t div_sel;
    logic    div_step;
    logic    gcd_start;
    logic    gcd_step;
    logic    save_num;
    logic    capture;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       b_zero;
    logic       rem_zero;
    logic       gcd_done;
    logic       g_ge2;
  } dp_stat_t;

endpackage

>>> rtl/smra_ctrl.sv
module smra_ctrl #(
  parameter int MAG_WIDTH = smra_pkg::MAG_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  smra_pkg::dp_stat_t stat,
  output smra_pkg::dp_cmd_t  ctl
);

  localparam int CW = $clog2(MAG_WIDTH);
  localparam logic [CW-1:0] LAST = CW'(MAG_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_DIVCHK,
    S_GCD,
    S_GCHK,
    S_DIVA,
    S_SAVEA,
    S_DIVB,
    S_DONE
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.div_sel = smra_pkg::DS_AB;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          smra_pkg::OP_MUL: begin
            ctl.mul_start = 1'b1;
            state_next    = S_MUL;
          end
          smra_pkg::OP_DIV: begin
            if (stat.b_zero) begin
              state_next = S_DONE;
            end else begin
              ctl.div_start = 1'b1;
              ctl.div_sel   = smra_pkg::DS_AB;
              state_next    = S_DIV;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MUL: begin
        ctl.mul_step = 1'b1;
        if (cnt == LAST) state_next = S_DONE;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == LAST) state_next = S_DIVCHK;
      end
      S_DIVCHK: begin
        if (stat.rem_zero) begin
          state_next = S_DONE;
        end else begin
          ctl.gcd_start = 1'b1;
          state_next    = S_GCD;
        end
      end
      S_GCD: begin
        ctl.gcd_step = 1'b1;
        if (stat.gcd_done) state_next = S_GCHK;
      end
      S_GCHK: begin
        if (stat.g_ge2) begin
          ctl.div_start = 1'b1;
          ctl.div_sel   = smra_pkg::DS_AG;
          state_next    = S_DIVA;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIVA: begin
        ctl.div_step = 1'b1;
        if (cnt == LAST) state_next = S_SAVEA;
      end
      S_SAVEA: begin
        ctl.save_num  = 1'b1;
        ctl.div_start = 1'b1;
        ctl.div_sel   = smra_pkg::DS_BG;
        state_next    = S_DIVB;
      end
      S_DIVB: begin
        ctl.div_step = 1'b1;
        if (cnt == LAST) state_next = S_DONE;
      end
      S_DONE: begin
        // output register free or emptied by a transfer this cycle
        if (!out_valid || !out_stall) begin
          ctl.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.mul_start || ctl.div_start) begin
        cnt <= '0;
      end else if (ctl.mul_step || ctl.div_step) begin
        cnt <= cnt + 1'b1;
      end
      if (ctl.capture) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "sign_magnitude_rational_alu_top_assert.svh"

  `SMRA_ASSERT_NEXT(a_accept_decode, clk, rst, in_valid && !in_stall, state == S_DECODE)
  `SMRA_ASSERT_NEXT(a_mul_len, clk, rst, state == S_MUL && cnt == LAST, state == S_DONE)
  `SMRA_ASSERT_NEXT(a_divb_len, clk, rst, state == S_DIVB && cnt == LAST, state == S_DONE)
  `SMRA_ASSERT_NEXT(a_capture_valid, clk, rst, ctl.capture, out_valid)

endmodule

>>> rtl/smra_datapath.sv
module smra_datapath #(
  parameter int MAG_WIDTH = smra_pkg::MAG_WIDTH_DEF
) (
  input  logic               clk,
  input  smra_pkg::dp_cmd_t  ctl,
  output smra_pkg::dp_stat_t stat,
  input  logic [1:0]         cmd,
  input  logic [31:0]        a_magnitude,
  input  logic               a_negative,
  input  logic [31:0]        b_magnitude,
  input  logic               b_negative,
  output logic [31:0]        res_magnitude,
  output logic               res_negative,
  output logic [31:0]        denom_magnitude,
  output logic               sign_flipped,
  output logic [2:0]         status
);

  localparam int W  = MAG_WIDTH;
  localparam int KW = $clog2(MAG_WIDTH);

  logic [63:0]   a_ext;
  logic [63:0]   b_ext;
  logic [1:0]    op;
  logic [W-1:0]  a;
  logic [W-1:0]  b;
  logic          as_r;
  logic          bs_r;
  logic [W-1:0]  acc;
  logic [W-1:0]  sh;
  logic [W-1:0]  dv;
  logic [W-1:0]  u;
  logic [W-1:0]  v;
  logic [KW-1:0] k;
  logic [W-1:0]  g;
  logic [W-1:0]  num_red;
  logic          inexact;

  logic [W:0]    rtmp;
  logic          rge;
  logic [W:0]    rdiff;
  logic [W:0]    msum;
  logic [W-1:0]  dnum;
  logic [W-1:0]  dden;

  logic          bs_eff;
  logic [W:0]    sum;
  logic          a_ge_b;
  logic [W-1:0]  r_mag;
  logic          r_neg;
  logic [W-1:0]  r_den;
  logic          r_flip;
  logic [2:0]    r_st;
  logic [63:0]   r_mag_ext;
  logic [63:0]   r_den_ext;

  assign a_ext = {32'b0, a_magnitude};
  assign b_ext = {32'b0, b_magnitude};

  // restoring divide step and shift-add multiply step share acc and sh
  assign rtmp  = {acc, sh[W-1]};
  assign rge   = (rtmp >= {1'b0, dv});
  assign rdiff = rtmp - {1'b0, dv};
  assign msum  = {1'b0, acc} + (sh[0] ? {1'b0, a} : '0);

  always_comb begin
    case (ctl.div_sel)
      smra_pkg::DS_AG: begin
        dnum = a;
        dden = g;
      end
      smra_pkg::DS_BG: begin
        dnum = b;
        dden = g;
      end
      default: begin
        dnum = a;
        dden = b;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op      <= cmd;
      a       <= a_ext[W-1:0];
      b       <= b_ext[W-1:0];
      as_r    <= a_negative;
      bs_r    <= b_negative;
      inexact <= 1'b0;
    end
    if (ctl.mul_start) begin
      acc <= '0;
      sh  <= b;
    end else if (ctl.div_start) begin
      acc <= '0;
      sh  <= dnum;
      dv  <= dden;
    end else if (ctl.mul_step) begin
      acc <= msum[W:1];
      sh  <= {msum[0], sh[W-1:1]};
    end else if (ctl.div_step) begin
      acc <= rge ? rdiff[W-1:0] : rtmp[W-1:0];
      sh  <= {sh[W-2:0], rge};
    end
    if (ctl.save_num) begin
      num_red <= sh;
    end
    // binary gcd, one step per cycle
    if (ctl.gcd_start) begin
      u       <= a;
      v       <= b;
      k       <= '0;
      inexact <= 1'b1;
    end else if (ctl.gcd_step) begin
      if (u == v) begin
        g <= u << k;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= (u - v) >> 1;
      end else begin
        v <= (v - u) >> 1;
      end
    end
    if (ctl.capture) begin
      res_magnitude   <= r_mag_ext[31:0];
      res_negative    <= r_neg;
      denom_magnitude <= r_den_ext[31:0];
      sign_flipped    <= r_flip;
      status          <= r_st;
    end
  end

  assign stat.op       = op;
  assign stat.b_zero   = (b == '0);
  assign stat.rem_zero = (acc == '0);
  assign stat.gcd_done = (u == v);
  assign stat.g_ge2    = |g[W-1:1];

  assign bs_eff = bs_r ^ (op == smra_pkg::OP_SUB);
  assign sum    = {1'b0, a} + {1'b0, b};
  assign a_ge_b = (a >= b);

  always_comb begin
    r_mag  = '0;
    r_neg  = 1'b0;
    r_den  = '0;
    r_flip = 1'b0;
    r_st   = smra_pkg::ST_OK;
    case (op)
      smra_pkg::OP_MUL: begin
        r_neg  = as_r ^ bs_r;
        r_flip = bs_r;
        if (acc != '0) begin
          r_mag = '1;
          r_st  = smra_pkg::ST_OVERFLOW;
        end else begin
          r_mag = sh;
        end
      end
      smra_pkg::OP_DIV: begin
        if (b == '0) begin
          r_st = smra_pkg::ST_DIVZERO;
        end else if (!inexact) begin
          r_mag  = sh;
          r_neg  = as_r ^ bs_r;
          r_flip = bs_r;
        end else if (g[W-1:1] != '0) begin
          r_mag = num_red;
          r_den = sh;
          r_neg = as_r;
          r_st  = smra_pkg::ST_REDUCED;
        end else begin
          r_mag = a;
          r_den = b;
          r_neg = as_r;
          r_st  = smra_pkg::ST_IRREDUCIBLE;
        end
      end
      default: begin
        if (as_r == bs_eff) begin
          r_neg = as_r;
          if (sum[W]) begin
            r_mag = '1;
            r_st  = smra_pkg::ST_OVERFLOW;
          end else begin
            r_mag = sum[W-1:0];
          end
        end else if (a_ge_b) begin
          r_mag = a - b;
          r_neg = as_r;
        end else begin
          r_mag = b - a;
          r_neg = bs_eff;
        end
      end
    endcase
  end

  assign r_mag_ext = 64'(r_mag);
  assign r_den_ext = 64'(r_den);

endmodule

>>> rtl/sign_magnitude_rational_alu_top.sv
// channel | handshake            | payload
// --------+----------------------+-------------------------------------------------
// in      | in_valid / in_stall  | cmd, a_magnitude, a_negative, b_magnitude,
//         |                      | b_negative
// out     | out_valid / out_stall| res_magnitude, res_negative, denom_magnitude,
//         |                      | sign_flipped, status
//
// one item at a time; add, subtract and divide by zero go from decode straight to done
// multiply runs one shift-add step per cycle; divide runs the restoring divider, and an
// inexact divide then runs binary gcd steps and, for a reducible fraction, two more
// divides on the shared restoring divider, for the reduced numerator and denominator
// synchronous reset clears the controller and the output valid, nothing else
// a result waits under out_stall while the next item runs and holds in its last step
module sign_magnitude_rational_alu_top #(
  parameter int MAG_WIDTH = smra_pkg::MAG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] a_magnitude,
  input  logic        a_negative,
  input  logic [31:0] b_magnitude,
  input  logic        b_negative,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] res_magnitude,
  output logic        res_negative,
  output logic [31:0] denom_magnitude,
  output logic        sign_flipped,
  output logic [2:0]  status
);

  smra_pkg::dp_cmd_t  ctl;
  smra_pkg::dp_stat_t stat;

  smra_ctrl #(
    .MAG_WIDTH(MAG_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  smra_datapath #(
    .MAG_WIDTH(MAG_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .ctl            (ctl),
    .stat           (stat),
    .cmd            (cmd),
    .a_magnitude    (a_magnitude),
    .a_negative     (a_negative),
    .b_magnitude    (b_magnitude),
    .b_negative     (b_negative),
    .res_magnitude  (res_magnitude),
    .res_negative   (res_negative),
    .denom_magnitude(denom_magnitude),
    .sign_flipped   (sign_flipped),
    .status         (status)
  );

endmodule

>>> dv/sign_magnitude_rational_alu_top_tb.sv
module sign_magnitude_rational_alu_top_tb;
  import smra_pkg::*;

  localparam logic [63:0] MAG_MASK = (64'd1 << MAG_WIDTH_DEF) - 64'd1;
  localparam logic [31:0] MX = 32'hFFFF_FFFF;
  localparam int N_DIR = 25;
  localparam int N_RANDOM = 1525;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] a_mag;
    logic        a_neg;
    logic [31:0] b_mag;
    logic        b_neg;
  } op_item_t;

  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic [31:0] den;
    logic        flip;
    logic [2:0]  st;
  } alu_result_t;

  typedef struct packed {
    op_item_t    item;
    logic        typed;
    alu_result_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = OP_ADD;
  logic [31:0] a_magnitude = '0;
  logic        a_negative = 1'b0;
  logic [31:0] b_magnitude = '0;
  logic        b_negative = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] res_magnitude;
  logic        res_negative;
  logic [31:0] denom_magnitude;
  logic        sign_flipped;
  logic [2:0]  status;

  alu_result_t pending_results[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned stall_cnt = 0;
  int unsigned stall_mode = 0;

  // extremes, signs of zero results, saturation, divide by zero, fractions
  dir_row_t dir_table [N_DIR] = '{
    '{'{OP_ADD, 32'd0, 1'b0, 32'd0, 1'b0}, 1'b1, '{32'd0, 1'b0, 32'd0, 1'b0, ST_OK}},
    '{'{OP_ADD, MX, 1'b0, 32'd1, 1'b0}, 1'b1, '{MX, 1'b0, 32'd0, 1'b0, ST_OVERFLOW}},
    '{'{OP_ADD, MX, 1'b1, MX, 1'b1}, 1'b1, '{MX, 1'b1, 32'd0, 1'b0, ST_OVERFLOW}},
    '{'{OP_ADD, 32'd5, 1'b0, 32'd5, 1'b1}, 1'b1, '{32'd0, 1'b0, 32'd0, 1'b0, ST_OK}},
    '{'{OP_ADD, 32'd5, 1'b1, 32'd5, 1'b0}, 1'b1, '{32'd0, 1'b1, 32'd0, 1'b0, ST_OK}},
    '{'{OP_ADD, MX, 1'b0, 32'd0, 1'b1}, 1'b1, '{MX, 1'b0, 32'd0, 1'b0, ST_OK}},
    '{'{OP_SUB, 32'd7, 1'b0, 32'd7, 1'b0}, 1'b1, '{32'd0, 1'b0, 32'd0, 1'b0, ST_OK}},
    '{'{OP_SUB, MX, 1'b1, MX, 1'b0}, 1'b1, '{MX, 1'b1, 32'd0, 1'b0, ST_OVERFLOW}},
    '{'{OP_SUB, 32'd3, 1'b0, 32'd10, 1'b0}, 1'b0, '0},
    '{'{OP_SUB, 32'd0, 1'b0, MX, 1'b0}, 1'b0, '0},
    '{'{OP_SUB, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
    '{'{OP_MUL, MX, 1'b0, 32'd1, 1'b0}, 1'b1, '{MX, 1'b0, 32'd0, 1'b0, ST_OK}},
    '{'{OP_MUL, MX, 1'b0, 32'd1, 1'b1}, 1'b1, '{MX, 1'b1, 32'd0, 1'b1, ST_OK}},
    '{'{OP_MUL, 32'd0, 1'b0, MX, 1'b1}, 1'b1, '{32'd0, 1'b1, 32'd0, 1'b1, ST_OK}},
    '{'{OP_MUL, 32'h1_0000, 1'b0, 32'h1_0000, 1'b0}, 1'b1,
      '{MX, 1'b0, 32'd0, 1'b0, ST_OVERFLOW}},
    '{'{OP_MUL, 32'h1_0000, 1'b1, 32'hFFFF, 1'b1}, 1'b0, '0},
    '{'{OP_DIV, 32'd5, 1'b0, 32'd0, 1'b0}, 1'b1, '{32'd0, 1'b0, 32'd0, 1'b0, ST_DIVZERO}},
    '{'{OP_DIV, MX, 1'b1, 32'd0, 1'b1}, 1'b1, '{32'd0, 1'b0, 32'd0, 1'b0, ST_DIVZERO}},
    '{'{OP_DIV, 32'd0, 1'b0, 32'd7, 1'b1}, 1'b1, '{32'd0, 1'b1, 32'd0, 1'b1, ST_OK}},
    '{'{OP_DIV, 32'd12, 1'b1, 32'd8, 1'b0}, 1'b1, '{32'd3, 1'b1, 32'd2, 1'b0, ST_REDUCED}},
    '{'{OP_DIV, 32'd7, 1'b0, 32'd3, 1'b1}, 1'b1,
      '{32'd7, 1'b0, 32'd3, 1'b0, ST_IRREDUCIBLE}},
    '{'{OP_DIV, MX, 1'b0, MX, 1'b1}, 1'b1, '{32'd1, 1'b1, 32'd0, 1'b1, ST_OK}},
    '{'{OP_DIV, MX, 1'b1, 32'd1, 1'b0}, 1'b1, '{MX, 1'b1, 32'd0, 1'b0, ST_OK}},
    '{'{OP_DIV, 32'hFFFF_FFFE, 1'b0, MX, 1'b0}, 1'b0, '0},
    '{'{OP_DIV, 32'h8000_0000, 1'b1, 32'hC000_0000, 1'b1}, 1'b0, '0}
  };

  sign_magnitude_rational_alu_top u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .a_magnitude     (a_magnitude),
    .a_negative      (a_negative),
    .b_magnitude     (b_magnitude),
    .b_negative      (b_negative),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .res_magnitude   (res_magnitude),
    .res_negative    (res_negative),
    .denom_magnitude (denom_magnitude),
    .sign_flipped    (sign_flipped),
    .status          (status)
  );

  always #1 clk = ~clk;

  function automatic alu_result_t sm_alu_compute(op_item_t it);
    logic [63:0] a, b, s, x, y, t;
    logic        bs;
    alu_result_t r;
    a = 64'(it.a_mag) & MAG_MASK;
    b = 64'(it.b_mag) & MAG_MASK;
    bs = it.b_neg;
    r = '0;
    case (it.cmd)
      OP_ADD, OP_SUB: begin
        if (it.cmd == OP_SUB) bs = ~bs;
        if (it.a_neg == bs) begin
          s = a + b;
          r.neg = it.a_neg;
          if (s > MAG_MASK) begin
            r.mag = MAG_MASK[31:0];
            r.st = ST_OVERFLOW;
          end else begin
            r.mag = s[31:0];
          end
        end else if (a >= b) begin
          r.mag = 32'(a - b);
          r.neg = it.a_neg;
        end else begin
          r.mag = 32'(b - a);
          r.neg = bs;
        end
      end
      OP_MUL: begin
        r.neg = it.a_neg ^ bs;
        r.flip = bs;
        if (a != 0 && b > MAG_MASK / a) begin
          r.mag = MAG_MASK[31:0];
          r.st = ST_OVERFLOW;
        end else begin
          r.mag = 32'(a * b);
        end
      end
      default: begin
        if (b == 0) begin
          r.st = ST_DIVZERO;
        end else if (a % b != 0) begin
          x = a;
          y = b;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          r.neg = it.a_neg;
          if (x >= 2) begin
            r.mag = 32'(a / x);
            r.den = 32'(b / x);
            r.st = ST_REDUCED;
          end else begin
            r.mag = a[31:0];
            r.den = b[31:0];
            r.st = ST_IRREDUCIBLE;
          end
        end else begin
          r.neg = it.a_neg ^ bs;
          r.flip = bs;
          r.mag = 32'(a / b);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 15);
      2: return MX - $urandom_range(0, 15);
      3: return 32'd1 << $urandom_range(0, 31);
      4: return $urandom_range(0, 32'hFFFF);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic op_item_t random_op();
    op_item_t    it;
    logic [31:0] g;
    it.cmd = 2'($urandom_range(0, 3));
    it.a_neg = 1'($urandom_range(0, 1));
    it.b_neg = 1'($urandom_range(0, 1));
    it.a_mag = rand_mag();
    it.b_mag = rand_mag();
    if (it.cmd == OP_DIV) begin
      case ($urandom_range(0, 3))
        // exact quotient
        0: begin
          it.b_mag = $urandom_range(1, 32'hFFFF);
          it.a_mag = it.b_mag * $urandom_range(0, 32'hFFFF);
        end
        // shared factor, reducible fraction
        1: begin
          g = $urandom_range(2, 255);
          it.a_mag = g * $urandom_range(0, 32'hFF_FFFF);
          it.b_mag = g * $urandom_range(1, 32'hFF_FFFF);
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input op_item_t it, input logic typed, input alu_result_t want);
    cmd <= it.cmd;
    a_magnitude <= it.a_mag;
    a_negative <= it.a_neg;
    b_magnitude <= it.b_mag;
    b_negative <= it.b_neg;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? want : sm_alu_compute(it));
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_table[i]) begin
      pace();
      send_item(dir_table[i].item, dir_table[i].typed, dir_table[i].want);
    end
    wait_drained();
    repeat (N_RANDOM) begin
      if ($urandom_range(0, 199) == 0) wait_drained();
      pace();
      send_item(random_op(), 1'b0, '0);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  always @(posedge clk) begin
    stall_cnt++;
    if (stall_cnt % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_cnt[3];
    endcase
  end

  always @(posedge clk) begin : check_result
    alu_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (res_magnitude !== want.mag) begin
          $error("res_magnitude: expected %0h, got %0h", want.mag, res_magnitude);
          mismatches++;
        end
        if (res_negative !== want.neg) begin
          $error("res_negative: expected %0b, got %0b", want.neg, res_negative);
          mismatches++;
        end
        if (denom_magnitude !== want.den) begin
          $error("denom_magnitude: expected %0h, got %0h", want.den, denom_magnitude);
          mismatches++;
        end
        if (sign_flipped !== want.flip) begin
          $error("sign_flipped: expected %0b, got %0b", want.flip, sign_flipped);
          mismatches++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/smra_pkg.sv
rtl/smra_ctrl.sv
rtl/smra_datapath.sv
rtl/sign_magnitude_rational_alu_top.sv
dv/sign_magnitude_rational_alu_top_tb.sv
